// File: hw/rtl/bss_pkg.sv
// Shared types, constants and the case-folding function of the substring search block.
package bss_pkg;

    localparam int MAX_PATTERN = 16;
    localparam int OFFSET_BITS = 16;
    localparam int PAT_BYTES   = 16;
    localparam int PAT_IDX_W   = $clog2(PAT_BYTES);
    localparam int LEN_W       = 5;
    localparam int CFG_IDX_W   = 2;
    localparam int CFG_DATA_W  = 64;

    localparam logic [CFG_IDX_W-1:0] CFG_PAT_LOW  = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_PAT_HIGH = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_PAT_LEN  = 2'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_CASE_INS = 2'd3;

    localparam logic [7:0] UPPER_FIRST = 8'h41;
    localparam logic [7:0] UPPER_LAST  = 8'h5A;
    localparam logic [7:0] CASE_DELTA  = 8'h20;

    typedef struct packed {
        logic [7:0] source_byte;
        logic       last_byte;
    } in_item_t;

    typedef struct packed {
        logic        found;
        logic [15:0] match_offset;
    } out_item_t;

    typedef struct packed {
        logic [MAX_PATTERN-1:0][7:0] pat_byte;
        logic [MAX_PATTERN-1:0]      use_en;
        logic [LEN_W-1:0]            len;
        logic                        case_ins;
    } cfg_t;

    function automatic logic [7:0] fold_byte(input logic [7:0] b, input logic case_ins);
        logic [7:0] r;
        r = b;
        if (case_ins && (b >= UPPER_FIRST) && (b <= UPPER_LAST))
        begin
            r = b + CASE_DELTA;
        end
        return r;
    endfunction

endpackage

// File: hw/rtl/bss_cfg.sv
// Configuration registers and the per-cell aligned, folded pattern bytes.
module bss_cfg
    import bss_pkg::*;
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  cfg_write_en,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_data,
    output cfg_t                  cfg
);

    logic [63:0]      pat_low_reg;
    logic [63:0]      pat_high_reg;
    logic [LEN_W-1:0] len_reg;
    logic             case_ins_reg;

    logic [PAT_BYTES-1:0][7:0] pat_all;
    logic [LEN_W-1:0]          len_eff;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pat_low_reg  <= '0;
            pat_high_reg <= '0;
            len_reg      <= '0;
            case_ins_reg <= 1'b0;
        end
        else if (cfg_write_en)
        begin
            unique case (cfg_index)
                CFG_PAT_LOW:  pat_low_reg  <= cfg_data[63:0];
                CFG_PAT_HIGH: pat_high_reg <= cfg_data[63:0];
                CFG_PAT_LEN:  len_reg      <= cfg_data[LEN_W-1:0];
                CFG_CASE_INS: case_ins_reg <= cfg_data[0];
                default:      ;
            endcase
        end
    end

    assign pat_all = {pat_high_reg, pat_low_reg};
    assign len_eff = (len_reg > LEN_W'(MAX_PATTERN)) ? LEN_W'(MAX_PATTERN) : len_reg;

    // Cell k holds the byte that must equal pattern byte len-1-k.
    always_comb
    begin
        logic [LEN_W-1:0] idx;
        cfg.len      = len_eff;
        cfg.case_ins = case_ins_reg;
        for (int k = 0; k < MAX_PATTERN; k++)
        begin
            idx            = LEN_W'(len_eff - LEN_W'(1) - LEN_W'(k));
            cfg.use_en[k]  = (LEN_W'(k) < len_eff);
            cfg.pat_byte[k] = fold_byte(pat_all[idx[PAT_IDX_W-1:0]], case_ins_reg);
        end
    end

endmodule

// File: hw/rtl/bss_cell.sv
// One window cell: holds a byte, passes it on, and compares the incoming byte.
module bss_cell
    import bss_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       shift,
    input  logic       clear,
    input  logic [7:0] prev_byte,
    input  logic [7:0] pat_byte,
    input  logic       use_en,
    input  logic       case_ins,
    output logic [7:0] byte_out,
    output logic       hit
);

    logic [7:0] byte_reg;
    logic [7:0] byte_next;

    always_comb
    begin
        byte_next = byte_reg;
        if (clear)
        begin
            byte_next = '0;
        end
        else if (shift)
        begin
            byte_next = prev_byte;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            byte_reg <= '0;
        end
        else
        begin
            byte_reg <= byte_next;
        end
    end

    assign byte_out = byte_reg;
    assign hit      = !use_en || (fold_byte(prev_byte, case_ins) == pat_byte);

endmodule

// File: hw/rtl/bounded_substring_search_core.sv
// Top level of the streaming first-occurrence substring search.
//
//   channel   signals                          direction
//   in        in_valid, in_ready, in_data      source bytes of a region
//   out       out_valid, out_ready, out_data   found flag and match offset
//   cfg       cfg_write_en, cfg_index, cfg_data  register writes
//
// One byte is taken per cycle; a result appears in the output register in the
// cycle after the byte that causes it. The window compare is done in parallel
// by the chain of cells, so a stall comes only from a held output register.
// Reset clears the configuration, the window, the byte count and out_valid.
module bounded_substring_search_core
    import bss_pkg::*;
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  in_valid,
    output logic                  in_ready,
    input  in_item_t              in_data,
    output logic                  out_valid,
    input  logic                  out_ready,
    output out_item_t             out_data,
    input  logic                  cfg_write_en,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_data
);

    cfg_t cfg;

    logic [MAX_PATTERN-1:0][7:0] win_byte;
    logic [MAX_PATTERN-1:0][7:0] prev_byte;
    logic [MAX_PATTERN-1:0]      cell_hit;

    logic [OFFSET_BITS-1:0] seen_reg;
    logic [OFFSET_BITS-1:0] seen_next;
    logic [OFFSET_BITS-1:0] seen_inc;
    logic [OFFSET_BITS-1:0] offset;
    logic                   reported_reg;
    logic                   reported_next;
    logic                   out_valid_reg;
    logic                   out_valid_next;
    out_item_t              out_reg;
    out_item_t              out_next;

    logic accept;
    logic shift;
    logic clear;
    logic match;

    bss_cfg u_cfg (
        .clk          (clk),
        .rst_n        (rst_n),
        .cfg_write_en (cfg_write_en),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data),
        .cfg          (cfg)
    );

    assign in_ready = !out_valid_reg || out_ready;
    assign accept   = in_valid && in_ready;
    assign shift    = accept && !reported_reg;
    assign clear    = accept && in_data.last_byte;

    genvar k;
    generate
        for (k = 0; k < MAX_PATTERN; k++)
        begin : g_cell
            if (k == 0)
            begin : g_head
                assign prev_byte[k] = in_data.source_byte;
            end
            else
            begin : g_body
                assign prev_byte[k] = win_byte[k-1];
            end

            bss_cell u_cell (
                .clk       (clk),
                .rst_n     (rst_n),
                .shift     (shift),
                .clear     (clear),
                .prev_byte (prev_byte[k]),
                .pat_byte  (cfg.pat_byte[k]),
                .use_en    (cfg.use_en[k]),
                .case_ins  (cfg.case_ins),
                .byte_out  (win_byte[k]),
                .hit       (cell_hit[k])
            );
        end
    endgenerate

    assign seen_inc = (seen_reg == '1) ? seen_reg : seen_reg + OFFSET_BITS'(1);
    assign offset   = (cfg.len == '0) ? '0 : seen_inc - OFFSET_BITS'(cfg.len);
    assign match    = (cfg.len == '0)
                   || ((seen_inc >= OFFSET_BITS'(cfg.len)) && (&cell_hit));

    always_comb
    begin
        seen_next      = seen_reg;
        reported_next  = reported_reg;
        out_valid_next = out_valid_reg && !out_ready;
        out_next       = out_reg;
        if (shift)
        begin
            seen_next = seen_inc;
            if (match)
            begin
                reported_next         = 1'b1;
                out_valid_next        = 1'b1;
                out_next.found        = 1'b1;
                out_next.match_offset = 16'(offset);
            end
            else if (in_data.last_byte)
            begin
                out_valid_next        = 1'b1;
                out_next.found        = 1'b0;
                out_next.match_offset = '0;
            end
        end
        if (clear)
        begin
            seen_next     = '0;
            reported_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            seen_reg      <= '0;
            reported_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            seen_reg      <= seen_next;
            reported_reg  <= reported_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        out_reg <= out_next;
    end

    assign out_valid = out_valid_reg;
    assign out_data  = out_reg;

    a_notfound_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && !out_data.found) |-> (out_data.match_offset == '0))
        else $error("not-found result carries a nonzero offset");

    a_region_clear: assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid && in_ready && in_data.last_byte) |=> (seen_reg == '0 && !reported_reg))
        else $error("region state not cleared after the last byte");

    a_reported_seen: assert property (@(posedge clk) disable iff (!rst_n)
        reported_reg |-> (seen_reg != '0))
        else $error("result reported with no byte counted");

    a_ready_rule: assert property (@(posedge clk) disable iff (!rst_n)
        in_ready == (!out_valid || out_ready))
        else $error("input ready does not follow the output register state");

endmodule

// File: test/tb.sv
`timescale 1ns / 100ps
// Self-checking testbench for bounded_substring_search_core with a built-in search predictor.
module tb;
    import bss_pkg::*;

    logic                  clk;
    logic                  rst_n;
    logic                  in_valid = 1'b0;
    logic                  in_ready;
    in_item_t              in_data = '0;
    logic                  out_valid;
    logic                  out_ready = 1'b0;
    out_item_t             out_data;
    logic                  cfg_write_en;
    logic [CFG_IDX_W-1:0]  cfg_index;
    logic [CFG_DATA_W-1:0] cfg_data;

    in_item_t  pending_bytes [$];
    out_item_t open_results [$];

    logic [127:0]           pat_image = '0;
    logic [LEN_W-1:0]       pat_len = '0;
    logic                   fold_en = 1'b0;
    logic [7:0]             window [MAX_PATTERN] = '{default: '0};
    logic [OFFSET_BITS-1:0] region_count = '0;
    bit                     region_done = 1'b0;

    int unsigned send_idle_pct = 0;
    int unsigned recv_idle_pct = 0;
    int unsigned stall_orders = 0;
    int unsigned stall_done = 0;
    int unsigned stall_left = 0;
    bit          in_took = 1'b0;

    int unsigned mismatches = 0;
    int unsigned bytes_sent = 0;
    int unsigned regions_sent = 0;
    int unsigned results_checked = 0;
    int unsigned matches_seen = 0;

    int unsigned phase_lens [9] = '{16, 3, 1, 31, 7, 0, 2, 12, 5};

    bounded_substring_search_core i_dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .in_valid     (in_valid),
        .in_ready     (in_ready),
        .in_data      (in_data),
        .out_valid    (out_valid),
        .out_ready    (out_ready),
        .out_data     (out_data),
        .cfg_write_en (cfg_write_en),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data)
    );

    initial
    begin
        clk = 1'b0;
        forever #1 clk = ~clk;
    end

    task automatic report_mismatch(input string msg);
        $display("mismatch at %0t: %s", $realtime, msg);
        mismatches++;
    endtask

    function automatic logic [7:0] lower_letter(input logic [7:0] b);
        if (fold_en && b >= 8'h41 && b <= 8'h5A)
        begin
            return b + CASE_DELTA;
        end
        return b;
    endfunction

    function automatic int unsigned used_len();
        return (pat_len > MAX_PATTERN) ? MAX_PATTERN : pat_len;
    endfunction

    function automatic bit is_letter(input logic [7:0] b);
        return ((b | CASE_DELTA) >= 8'h61) && ((b | CASE_DELTA) <= 8'h7A);
    endfunction

    task automatic advance_search(input in_item_t it);
        int unsigned n;
        bit          hit;
        logic [15:0] ofs;
        out_item_t   res;
        n = used_len();
        if (!region_done)
        begin
            for (int k = MAX_PATTERN - 1; k > 0; k--)
            begin
                window[k] = window[k - 1];
            end
            window[0] = it.source_byte;
            if (region_count != '1)
            begin
                region_count++;
            end
            hit = 1'b0;
            ofs = '0;
            if (n == 0)
            begin
                hit = 1'b1;
            end
            else if (region_count >= n)
            begin
                hit = 1'b1;
                for (int k = 0; k < n; k++)
                begin
                    if (lower_letter(window[n - 1 - k]) != lower_letter(pat_image[8*k +: 8]))
                    begin
                        hit = 1'b0;
                    end
                end
                ofs = 16'(region_count - n);
            end
            if (hit)
            begin
                res.found = 1'b1;
                res.match_offset = ofs;
                open_results.push_back(res);
                region_done = 1'b1;
            end
            else if (it.last_byte)
            begin
                res = '0;
                open_results.push_back(res);
            end
        end
        if (it.last_byte)
        begin
            window = '{default: '0};
            region_count = '0;
            region_done = 1'b0;
        end
    endtask

    always @(posedge clk)
    begin
        out_item_t want;
        in_took = in_valid && in_ready;
        if (rst_n)
        begin
            if (in_took)
            begin
                advance_search(in_data);
                bytes_sent++;
                if (in_data.last_byte)
                begin
                    regions_sent++;
                end
            end
            if (out_valid && out_ready)
            begin
                results_checked++;
                if (open_results.size() == 0)
                begin
                    report_mismatch($sformatf("result found=%0b offset=%0d with none expected",
                                              out_data.found, out_data.match_offset));
                end
                else
                begin
                    want = open_results.pop_front();
                    if (want.found)
                    begin
                        matches_seen++;
                    end
                    if (out_data.found !== want.found)
                    begin
                        report_mismatch($sformatf("found %0b, expected %0b",
                                                  out_data.found, want.found));
                    end
                    if (out_data.match_offset !== want.match_offset)
                    begin
                        report_mismatch($sformatf("match_offset %0d, expected %0d",
                                                  out_data.match_offset, want.match_offset));
                    end
                end
            end
        end
    end

    always @(negedge clk)
    begin
        if (rst_n && !(in_valid && !in_took))
        begin
            if (pending_bytes.size() != 0 && $urandom_range(0, 99) >= send_idle_pct)
            begin
                in_valid <= 1'b1;
                in_data  <= pending_bytes.pop_front();
            end
            else
            begin
                in_valid <= 1'b0;
            end
        end
    end

    always @(negedge clk)
    begin
        if (stall_done != stall_orders)
        begin
            stall_done = stall_orders;
            stall_left = 300;
        end
        if (stall_left > 0)
        begin
            stall_left--;
            out_ready <= 1'b0;
        end
        else
        begin
            out_ready <= ($urandom_range(0, 99) >= recv_idle_pct);
        end
    end

    task automatic load_pattern(input logic [127:0] image, input logic [LEN_W-1:0] len,
                                input logic ci);
        @(negedge clk);
        cfg_write_en <= 1'b1;
        cfg_index    <= CFG_PAT_LOW;
        cfg_data     <= image[63:0];
        @(negedge clk);
        cfg_index    <= CFG_PAT_HIGH;
        cfg_data     <= image[127:64];
        @(negedge clk);
        cfg_index    <= CFG_PAT_LEN;
        cfg_data     <= {$urandom(), 27'($urandom()), len};
        @(negedge clk);
        cfg_index    <= CFG_CASE_INS;
        cfg_data     <= {$urandom(), 31'($urandom()), ci};
        @(negedge clk);
        cfg_write_en <= 1'b0;
        pat_image = image;
        pat_len   = len;
        fold_en   = ci;
    endtask

    task automatic wait_idle();
        do
        begin
            @(posedge clk);
        end
        while (pending_bytes.size() != 0 || in_valid || open_results.size() != 0);
        repeat (4) @(negedge clk);
    endtask

    task automatic queue_text(input string s);
        in_item_t item;
        for (int k = 0; k < s.len(); k++)
        begin
            item.source_byte = s[k];
            item.last_byte   = (k == s.len() - 1);
            pending_bytes.push_back(item);
        end
    endtask

    function automatic logic [7:0] noise_byte();
        logic [7:0] b;
        if (used_len() == 0 || $urandom_range(0, 9) > 6)
        begin
            return 8'($urandom());
        end
        b = pat_image[8*$urandom_range(0, used_len() - 1) +: 8];
        if (is_letter(b) && $urandom_range(0, 1))
        begin
            b ^= CASE_DELTA;
        end
        return b;
    endfunction

    function automatic logic [127:0] random_pattern();
        logic [127:0] img;
        for (int k = 0; k < MAX_PATTERN; k++)
        begin
            if ($urandom_range(0, 3) == 0)
            begin
                img[8*k +: 8] = 8'($urandom());
            end
            else
            begin
                img[8*k +: 8] = 8'(8'h61 + $urandom_range(0, 3))
                                ^ ($urandom_range(0, 1) ? CASE_DELTA : 8'h00);
            end
        end
        return img;
    endfunction

    task automatic queue_region(input int unsigned span, input bit plant);
        logic [7:0]  bytes_q [$];
        int unsigned n;
        int unsigned start_pos;
        in_item_t    item;
        n = used_len();
        for (int k = 0; k < span; k++)
        begin
            bytes_q.push_back(noise_byte());
        end
        if (plant && n > 0 && span >= n)
        begin
            start_pos = $urandom_range(0, span - n);
            for (int k = 0; k < n; k++)
            begin
                bytes_q[start_pos + k] = pat_image[8*k +: 8];
                if (fold_en && is_letter(bytes_q[start_pos + k]) && $urandom_range(0, 1))
                begin
                    bytes_q[start_pos + k] ^= CASE_DELTA;
                end
            end
        end
        for (int k = 0; k < span; k++)
        begin
            item.source_byte = bytes_q[k];
            item.last_byte   = (k == span - 1);
            pending_bytes.push_back(item);
        end
    endtask

    task automatic run_random(input int budget);
        int          left;
        int unsigned n;
        int unsigned span;
        bit          plant;
        left = budget;
        n = used_len();
        while (left > 0)
        begin
            case ($urandom_range(0, 9))
                0, 1, 2, 3, 4, 5:
                begin
                    span  = n + $urandom_range(0, 10);
                    plant = 1'b1;
                end
                6, 7:
                begin
                    span  = $urandom_range(1, n + 1);
                    plant = 1'b0;
                end
                8:
                begin
                    span  = $urandom_range(20, 40);
                    plant = 1'b1;
                end
                default:
                begin
                    span  = $urandom_range(1, 20);
                    plant = 1'b0;
                end
            endcase
            if (span == 0)
            begin
                span = 1;
            end
            queue_region(span, plant);
            left -= span;
        end
    endtask

    initial
    begin
        in_item_t item;
        rst_n        = 1'b0;
        cfg_write_en = 1'b0;
        cfg_index    = '0;
        cfg_data     = '0;
        repeat (7) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        // Empty pattern after reset: each region matches at its first byte.
        item = '{source_byte: 8'h00, last_byte: 1'b0};
        pending_bytes.push_back(item);
        item = '{source_byte: 8'hFF, last_byte: 1'b1};
        pending_bytes.push_back(item);
        queue_text("U");
        wait_idle();

        load_pattern(128'h436241, 5'd3, 1'b1);
        queue_text("xaBcz");
        queue_text("ab");
        queue_text("abc");
        queue_text("@bc");
        wait_idle();

        load_pattern(128'h436241, 5'd3, 1'b0);
        queue_text("abc");
        queue_text("AbC");
        wait_idle();

        load_pattern({8{16'hFF00}}, 5'd16, 1'b0);
        for (int k = 0; k < MAX_PATTERN; k++)
        begin
            item.source_byte = (k % 2) ? 8'hFF : 8'h00;
            item.last_byte   = (k == MAX_PATTERN - 1);
            pending_bytes.push_back(item);
        end
        wait_idle();

        for (int s = 0; s < 3; s++)
        begin
            send_idle_pct = (s == 0) ? 25 : (s == 1) ? 73 : 0;
            recv_idle_pct = (s == 0) ? 73 : (s == 1) ? 25 : 0;
            for (int c = 0; c < 3; c++)
            begin
                load_pattern(random_pattern(), LEN_W'(phase_lens[3*s + c]), 1'((s + c) % 2));
                run_random(35);
                wait_idle();
            end
        end

        // Long output stall with one result per short region, so the input backs up.
        load_pattern(random_pattern(), 5'd0, 1'b0);
        stall_orders++;
        for (int k = 0; k < 60; k++)
        begin
            queue_region($urandom_range(1, 2), 1'b0);
        end
        wait_idle();

        repeat (8) @(negedge clk);
        $display("Sent %0d bytes in %0d regions under three idle mixes and a long output stall;",
                 bytes_sent, regions_sent);
        $display("checked %0d results, %0d of them matches.",
                 results_checked, matches_seen);
        if (mismatches == 0 && open_results.size() == 0)
        begin
            $display("status: pass");
        end
        else
        begin
            $display("status: fail");
        end
        $finish;
    end

    initial
    begin
        #2_000_000;
        $display("Timed out with %0d results still expected.", open_results.size());
        $display("status: fail");
        $finish;
    end

endmodule

// File: sim.f
hw/rtl/bss_pkg.sv
hw/rtl/bss_cfg.sv
hw/rtl/bss_cell.sv
hw/rtl/bounded_substring_search_core.sv
test/tb.sv
